### design/slpg_pkg.sv
// shared types and constants for the status led pattern generator
// no dependencies; imported by every module of the block
`default_nettype none

package slpg_pkg;

   localparam int unsigned NOW_WIDTH      = 32;
   localparam int unsigned INTERVAL_WIDTH = 16;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_IDX_WIDTH  = 3;
   localparam int unsigned PULSE_WIDTH    = 11;

   localparam int unsigned PULSE_STEP = 8;

   localparam logic signed [PULSE_WIDTH-1:0] DIM_LIMIT    = 11'sd32;
   localparam logic signed [PULSE_WIDTH-1:0] BRIGHT_LIMIT = 11'sd255;
   localparam logic signed [PULSE_WIDTH:0]   PULSE_MAX    = 12'sd1023;
   localparam logic signed [PULSE_WIDTH:0]   PULSE_MIN    = -12'sd1024;

   localparam logic [7:0] WHEEL_THIRD     = 8'h55;
   localparam logic [7:0] WHEEL_TWO_THIRD = 8'hAA;
   localparam logic [7:0] CHAN_FULL       = 8'hFF;
   localparam logic [7:0] BRIGHT_RESET    = 8'hFF;

   typedef enum logic [1:0] {
      MODE_FIXED  = 2'd0,
      MODE_PULSE  = 2'd1,
      MODE_WHEEL  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_MODE     = 3'd0,
      REG_ENABLE   = 3'd1,
      REG_RED      = 3'd2,
      REG_GREEN    = 3'd3,
      REG_BLUE     = 3'd4,
      REG_INTERVAL = 3'd5,
      REG_BRIGHT   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [1:0]                mode_select;
      logic                      show_enable;
      logic [7:0]                base_red;
      logic [7:0]                base_green;
      logic [7:0]                base_blue;
      logic [INTERVAL_WIDTH-1:0] step_interval;
      logic [7:0]                brightness;
   } cfg_type;

   typedef struct packed {
      logic changed;
      logic blank_set;
      logic blank_clr;
   } cfg_event_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] brightness;
   } colour_type;

endpackage

`default_nettype wire

### design/slpg_csr.sv
// configuration registers and change detection
// depends on slpg_pkg
`default_nettype none

module slpg_csr
   import slpg_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata,
   output cfg_type                        cfg,
   output cfg_event_type                  cfg_event
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   cfg_event_type event_in;

   always_comb begin
      cfg_in   = cfg_ff;
      event_in = '0;
      if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_MODE: begin
               cfg_in.mode_select = csr_wdata[1:0];
               event_in.changed   = (csr_wdata[1:0] != cfg_ff.mode_select);
            end
            REG_ENABLE: begin
               cfg_in.show_enable = csr_wdata[0];
               event_in.changed   = (csr_wdata[0] != cfg_ff.show_enable);
               event_in.blank_set = event_in.changed && !csr_wdata[0];
               event_in.blank_clr = event_in.changed && csr_wdata[0];
            end
            REG_RED: begin
               cfg_in.base_red  = csr_wdata[7:0];
               event_in.changed = (csr_wdata[7:0] != cfg_ff.base_red);
            end
            REG_GREEN: begin
               cfg_in.base_green = csr_wdata[7:0];
               event_in.changed  = (csr_wdata[7:0] != cfg_ff.base_green);
            end
            REG_BLUE: begin
               cfg_in.base_blue = csr_wdata[7:0];
               event_in.changed = (csr_wdata[7:0] != cfg_ff.base_blue);
            end
            REG_INTERVAL: cfg_in.step_interval = csr_wdata[INTERVAL_WIDTH-1:0];
            REG_BRIGHT:   cfg_in.brightness    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode_select: '0, show_enable: 1'b0, base_red: '0, base_green: '0,
                     base_blue: '0, step_interval: '0, brightness: BRIGHT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg       = cfg_ff;
   assign cfg_event = event_in;

endmodule

`default_nettype wire

### design/slpg_core.sv
// pattern state and combinational step logic: interval check, breathing, colour wheel
// depends on slpg_pkg
`default_nettype none

module slpg_core
   import slpg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire cfg_event_type        cfg_event,
   input  wire logic                 step,
   input  wire logic [NOW_WIDTH-1:0] now_ms,
   output logic                      emit,
   output colour_type                colour
);

   localparam logic signed [PULSE_WIDTH:0] STEP_POS = (PULSE_WIDTH+1)'(PULSE_STEP);

   logic [NOW_WIDTH-1:0]          last_time_ff, last_time_in;
   logic signed [PULSE_WIDTH-1:0] pulse_ff [3], pulse_in [3];
   logic                          rising_ff, rising_in;
   logic [7:0]                    wheel_pos_ff, wheel_pos_in;
   logic                          update_ff, update_in;
   logic                          reload_ff, reload_in;
   logic                          blank_ff, blank_in;

   logic [NOW_WIDTH-1:0]          elapsed;
   logic signed [PULSE_WIDTH-1:0] pulse_src [3];
   logic signed [PULSE_WIDTH:0]   pulse_sum [3];
   logic signed [PULSE_WIDTH-1:0] pulse_new [3];
   logic [7:0]                    base [3];
   logic [7:0]                    wc;
   logic [7:0]                    wc_off;
   logic [9:0]                    wc3;
   logic [7:0]                    up_ramp, down_ramp;
   logic [7:0]                    wheel_rgb [3];
   logic [7:0]                    pulse_rgb [3];
   logic                          all_bright, all_dim;

   assign base[0] = cfg.base_red;
   assign base[1] = cfg.base_green;
   assign base[2] = cfg.base_blue;

   // breathing step
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pulse_src[i] = reload_ff ? signed'({3'b000, base[i]}) : pulse_ff[i];
         pulse_sum[i] = rising_ff ? ({pulse_src[i][PULSE_WIDTH-1], pulse_src[i]} + STEP_POS)
                                  : ({pulse_src[i][PULSE_WIDTH-1], pulse_src[i]} - STEP_POS);
         if (pulse_sum[i] > PULSE_MAX) begin
            pulse_new[i] = PULSE_MAX[PULSE_WIDTH-1:0];
         end else if (pulse_sum[i] < PULSE_MIN) begin
            pulse_new[i] = PULSE_MIN[PULSE_WIDTH-1:0];
         end else begin
            pulse_new[i] = pulse_sum[i][PULSE_WIDTH-1:0];
         end
         if (pulse_new[i] < 0) begin
            pulse_rgb[i] = '0;
         end else if (pulse_new[i] > BRIGHT_LIMIT) begin
            pulse_rgb[i] = CHAN_FULL;
         end else begin
            pulse_rgb[i] = pulse_new[i][7:0];
         end
      end
      all_bright = (pulse_new[0] >= BRIGHT_LIMIT) && (pulse_new[1] >= BRIGHT_LIMIT) &&
                   (pulse_new[2] >= BRIGHT_LIMIT);
      all_dim    = (pulse_new[0] <= DIM_LIMIT) && (pulse_new[1] <= DIM_LIMIT) &&
                   (pulse_new[2] <= DIM_LIMIT);
   end

   // colour wheel
   always_comb begin
      wc = CHAN_FULL - wheel_pos_ff;
      if (wc < WHEEL_THIRD) begin
         wc_off = wc;
      end else if (wc < WHEEL_TWO_THIRD) begin
         wc_off = wc - WHEEL_THIRD;
      end else begin
         wc_off = wc - WHEEL_TWO_THIRD;
      end
      wc3       = {2'b00, wc_off} + {1'b0, wc_off, 1'b0};
      up_ramp   = wc3[7:0];
      down_ramp = CHAN_FULL - wc3[7:0];
      if (wc < WHEEL_THIRD) begin
         wheel_rgb[0] = up_ramp;
         wheel_rgb[1] = down_ramp;
         wheel_rgb[2] = '0;
      end else if (wc < WHEEL_TWO_THIRD) begin
         wheel_rgb[0] = down_ramp;
         wheel_rgb[1] = '0;
         wheel_rgb[2] = up_ramp;
      end else begin
         wheel_rgb[0] = '0;
         wheel_rgb[1] = up_ramp;
         wheel_rgb[2] = down_ramp;
      end
   end

   assign elapsed = now_ms - last_time_ff;

   always_comb begin
      last_time_in = last_time_ff;
      pulse_in     = pulse_ff;
      rising_in    = rising_ff;
      wheel_pos_in = wheel_pos_ff;
      update_in    = update_ff;
      reload_in    = reload_ff;
      blank_in     = blank_ff;
      emit         = 1'b0;
      colour       = '0;
      colour.brightness = cfg.brightness;

      if (cfg_event.changed) begin
         update_in = 1'b1;
         reload_in = 1'b1;
      end
      if (cfg_event.blank_set) begin
         blank_in = 1'b1;
      end
      if (cfg_event.blank_clr) begin
         blank_in = 1'b0;
      end

      if (step) begin
         if (!cfg.show_enable) begin
            // blank once after disable
            if (blank_ff) begin
               blank_in = 1'b0;
               emit     = 1'b1;
            end
         end else if (elapsed >= NOW_WIDTH'(cfg.step_interval)) begin
            last_time_in = now_ms;
            case (mode_type'(cfg.mode_select))
               MODE_PULSE: begin
                  pulse_in = pulse_new;
                  if (rising_ff && all_bright) begin
                     rising_in = 1'b0;
                  end else if (!rising_ff && all_dim) begin
                     rising_in = 1'b1;
                  end
                  emit         = 1'b1;
                  colour.red   = pulse_rgb[0];
                  colour.green = pulse_rgb[1];
                  colour.blue  = pulse_rgb[2];
               end
               MODE_WHEEL: begin
                  wheel_pos_in = wheel_pos_ff + 8'd1;
                  emit         = 1'b1;
                  colour.red   = wheel_rgb[0];
                  colour.green = wheel_rgb[1];
                  colour.blue  = wheel_rgb[2];
               end
               default: begin
                  emit         = update_ff;
                  colour.red   = cfg.base_red;
                  colour.green = cfg.base_green;
                  colour.blue  = cfg.base_blue;
               end
            endcase
            if (emit) begin
               update_in = 1'b0;
               reload_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         pulse_ff     <= '{default: '0};
         rising_ff    <= 1'b0;
         wheel_pos_ff <= '0;
         update_ff    <= 1'b1;
         reload_ff    <= 1'b1;
         blank_ff     <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         pulse_ff     <= pulse_in;
         rising_ff    <= rising_in;
         wheel_pos_ff <= wheel_pos_in;
         update_ff    <= update_in;
         reload_ff    <= reload_in;
         blank_ff     <= blank_in;
      end
   end

endmodule

`default_nettype wire

### design/status_led_pattern_generator.sv
// Status LED pattern generator. Each transaction on the req_ channel carries a
// millisecond timestamp; when step_interval has passed the selected pattern (fixed
// colour, breathing, colour wheel) takes one step and may return one colour on the
// rsp_ channel. One transaction is accepted per cycle unless the input is stalled; a
// result passes from the input register through the combinational step logic into the
// result register. A result held by a low rsp_ready stalls the input. The user is to
// write configuration through the csr_ port while idle; the block does not enforce it.
// depends on slpg_pkg, slpg_csr, slpg_core
`default_nettype none

module status_led_pattern_generator
   import slpg_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [NOW_WIDTH-1:0]      req_now_ms,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [7:0]                     rsp_out_red,
   output logic [7:0]                     rsp_out_green,
   output logic [7:0]                     rsp_out_blue,
   output logic [7:0]                     rsp_out_brightness,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type              cfg;
   cfg_event_type        cfg_event;
   logic                 in_valid_ff, in_valid_in;
   logic [NOW_WIDTH-1:0] now_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   colour_type           rsp_ff;
   logic                 fire;
   logic                 emit;
   colour_type           colour;

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_event (cfg_event)
   );

   slpg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_event (cfg_event),
      .step      (fire),
      .now_ms    (now_ff),
      .emit      (emit),
      .colour    (colour)
   );

   assign fire         = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || fire;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = fire ? emit : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ff <= req_now_ms;
      end
      if (fire && emit) begin
         rsp_ff <= colour;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_red        = rsp_ff.red;
   assign rsp_out_green      = rsp_ff.green;
   assign rsp_out_blue       = rsp_ff.blue;
   assign rsp_out_brightness = rsp_ff.brightness;

endmodule

`default_nettype wire

### test/status_led_pattern_generator_tb.sv
// self-checking testbench for the status led pattern generator: directed and random
// timestamps under varied idling, results checked against a behavioural colour tracker
// depends on slpg_pkg and status_led_pattern_generator
`timescale 1ns / 100ps

module status_led_pattern_generator_tb
   import slpg_pkg::*;
();

   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_PHASE   = 5;
   localparam int PHASES       = 10;

   class colour_tracker;
      cfg_type                        settings;
      logic [NOW_WIDTH-1:0]           last_step_stamp;
      logic signed [PULSE_WIDTH-1:0]  level_red, level_green, level_blue;
      logic                           rising;
      logic [7:0]                     wheel_pos;
      logic                           update_due, reload_due, blank_due;
      colour_type                     expected_colours[$];
      int unsigned                    mismatches;

      function new();
         settings            = '0;
         settings.brightness = BRIGHT_RESET;
         last_step_stamp     = '0;
         level_red           = '0;
         level_green         = '0;
         level_blue          = '0;
         rising              = 1'b0;
         wheel_pos           = '0;
         update_due          = 1'b1;
         reload_due          = 1'b1;
         blank_due           = 1'b0;
         mismatches          = 0;
      endfunction

      function int pending();
         return expected_colours.size();
      endfunction

      function logic signed [PULSE_WIDTH-1:0] saturate_level(int v);
         if (v < int'(PULSE_MIN)) v = int'(PULSE_MIN);
         else if (v > int'(PULSE_MAX)) v = int'(PULSE_MAX);
         return v[PULSE_WIDTH-1:0];
      endfunction

      function logic [7:0] clip_channel(int v);
         if (v < 0) return 8'h00;
         if (v > int'(CHAN_FULL)) return CHAN_FULL;
         return v[7:0];
      endfunction

      function void write_register(reg_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
         logic changed;
         changed = 1'b0;
         case (idx)
            REG_MODE: begin
               changed = settings.mode_select != value[1:0];
               settings.mode_select = value[1:0];
            end
            REG_ENABLE: begin
               changed = settings.show_enable != value[0];
               if (changed) blank_due = !value[0];
               settings.show_enable = value[0];
            end
            REG_RED: begin
               changed = settings.base_red != value[7:0];
               settings.base_red = value[7:0];
            end
            REG_GREEN: begin
               changed = settings.base_green != value[7:0];
               settings.base_green = value[7:0];
            end
            REG_BLUE: begin
               changed = settings.base_blue != value[7:0];
               settings.base_blue = value[7:0];
            end
            REG_INTERVAL: settings.step_interval = value[INTERVAL_WIDTH-1:0];
            REG_BRIGHT:   settings.brightness = value[7:0];
            default: ;
         endcase
         if (changed) begin
            update_due = 1'b1;
            reload_due = 1'b1;
         end
      endfunction

      function void note_timestamp(logic [NOW_WIDTH-1:0] stamp);
         logic [NOW_WIDTH-1:0] elapsed;
         int                   r, g, b, c, step;
         colour_type           col;
         if (!settings.show_enable) begin
            if (blank_due) begin
               blank_due = 1'b0;
               expected_colours.push_back({8'h00, 8'h00, 8'h00, settings.brightness});
            end
            return;
         end
         elapsed = stamp - last_step_stamp;
         if (elapsed < NOW_WIDTH'(settings.step_interval)) return;
         last_step_stamp = stamp;
         case (mode_type'(settings.mode_select))
            MODE_PULSE: begin
               if (reload_due) begin
                  level_red   = signed'({3'b000, settings.base_red});
                  level_green = signed'({3'b000, settings.base_green});
                  level_blue  = signed'({3'b000, settings.base_blue});
               end
               step        = rising ? int'(PULSE_STEP) : -int'(PULSE_STEP);
               level_red   = saturate_level(level_red + step);
               level_green = saturate_level(level_green + step);
               level_blue  = saturate_level(level_blue + step);
               if (rising) begin
                  if (level_red >= BRIGHT_LIMIT && level_green >= BRIGHT_LIMIT
                      && level_blue >= BRIGHT_LIMIT) rising = 1'b0;
               end else if (level_red <= DIM_LIMIT && level_green <= DIM_LIMIT
                            && level_blue <= DIM_LIMIT) begin
                  rising = 1'b1;
               end
               r = level_red;
               g = level_green;
               b = level_blue;
            end
            MODE_WHEEL: begin
               c = int'(CHAN_FULL) - int'(wheel_pos);
               if (c < int'(WHEEL_THIRD)) begin
                  r = 3 * c;
                  g = int'(CHAN_FULL) - 3 * c;
                  b = 0;
               end else if (c < int'(WHEEL_TWO_THIRD)) begin
                  c = c - int'(WHEEL_THIRD);
                  r = int'(CHAN_FULL) - 3 * c;
                  g = 0;
                  b = 3 * c;
               end else begin
                  c = c - int'(WHEEL_TWO_THIRD);
                  r = 0;
                  g = 3 * c;
                  b = int'(CHAN_FULL) - 3 * c;
               end
               wheel_pos = wheel_pos + 8'd1;
            end
            default: begin
               if (!update_due) return;
               r = settings.base_red;
               g = settings.base_green;
               b = settings.base_blue;
            end
         endcase
         update_due     = 1'b0;
         reload_due     = 1'b0;
         col.red        = clip_channel(r);
         col.green      = clip_channel(g);
         col.blue       = clip_channel(b);
         col.brightness = settings.brightness;
         expected_colours.push_back(col);
      endfunction

      function void report_mismatch(string text);
         mismatches++;
         if (mismatches <= 10) $display("%0t %s", $time, text);
      endfunction

      function void check_colour(colour_type seen);
         colour_type want;
         if (expected_colours.size() == 0) begin
            report_mismatch($sformatf("unexpected colour r=%0d g=%0d b=%0d br=%0d",
                                      seen.red, seen.green, seen.blue, seen.brightness));
            return;
         end
         want = expected_colours.pop_front();
         if (seen.red !== want.red || seen.green !== want.green || seen.blue !== want.blue
             || seen.brightness !== want.brightness)
            report_mismatch($sformatf(
               "colour mismatch: expected r=%0d g=%0d b=%0d br=%0d, got r=%0d g=%0d b=%0d br=%0d",
               want.red, want.green, want.blue, want.brightness,
               seen.red, seen.green, seen.blue, seen.brightness));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [NOW_WIDTH-1:0]      req_now_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_brightness;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = REG_MODE;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   colour_tracker             tracker = new();
   int                        sender_idle_pct = 0;
   int                        receiver_stall_pct = 0;
   logic                      hold_request = 1'b0;
   int                        held_cycles = 0;
   logic [NOW_WIDTH-1:0]      stamp_now = '0;
   logic [INTERVAL_WIDTH-1:0] current_interval = '0;
   mode_type                  phase_modes[PHASES] = '{MODE_PULSE, MODE_WHEEL, MODE_PULSE,
      MODE_FIXED, MODE_PULSE, MODE_WHEEL, MODE_UNUSED, MODE_PULSE, MODE_WHEEL, MODE_PULSE};

   status_led_pattern_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_now_ms         (req_now_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_out_brightness (rsp_out_brightness),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver: random stalls, plus one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request && held_cycles < LONG_HOLD) begin
         rsp_ready   <= 1'b0;
         held_cycles <= held_cycles + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) tracker.note_timestamp(req_now_ms);
         if (rsp_valid && rsp_ready)
            tracker.check_colour({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_brightness});
      end
   end

   task automatic send_timestamp(input logic [NOW_WIDTH-1:0] stamp);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_now_ms <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(idx, value);
   endtask

   // unused upper data bits carry noise
   task automatic apply_settings(input cfg_type s);
      write_register(REG_MODE, {14'($urandom()), s.mode_select});
      write_register(REG_ENABLE, {15'($urandom()), s.show_enable});
      write_register(REG_RED, {8'($urandom()), s.base_red});
      write_register(REG_GREEN, {8'($urandom()), s.base_green});
      write_register(REG_BLUE, {8'($urandom()), s.base_blue});
      write_register(REG_INTERVAL, s.step_interval);
      write_register(REG_BRIGHT, {8'($urandom()), s.brightness});
      csr_wr_en        <= 1'b0;
      current_interval = s.step_interval;
   endtask

   task automatic run_directed(input cfg_type s, input logic [NOW_WIDTH-1:0] first,
                               input logic [NOW_WIDTH-1:0] stride, input int count);
      wait_until_drained();
      apply_settings(s);
      for (int k = 0; k < count; k++) send_timestamp(first + stride * k);
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return CHAN_FULL;
         2:       return 8'($urandom_range(40, 24));
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic cfg_type random_settings(input mode_type mode);
      cfg_type s;
      s.mode_select = mode;
      s.show_enable = ($urandom_range(99) < 85);
      s.base_red    = pick_channel();
      s.base_green  = pick_channel();
      s.base_blue   = pick_channel();
      case ($urandom_range(4))
         0:       s.step_interval = '0;
         1:       s.step_interval = '1;
         2:       s.step_interval = INTERVAL_WIDTH'($urandom_range(3, 1));
         default: s.step_interval = INTERVAL_WIDTH'($urandom_range(500));
      endcase
      case ($urandom_range(3))
         0:       s.brightness = 8'h00;
         1:       s.brightness = CHAN_FULL;
         default: s.brightness = 8'($urandom());
      endcase
      return s;
   endfunction

   // mostly steps that clear the interval, some too early, some arbitrary
   function automatic logic [NOW_WIDTH-1:0] next_stamp();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) return $urandom();
      if (pick < 25) stamp_now = stamp_now + $urandom_range(current_interval);
      else stamp_now = stamp_now + current_interval + $urandom_range(3);
      return stamp_now;
   endfunction

   initial begin
      cfg_type s;
      int      n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // disabled with nothing to blank
      send_timestamp(32'd0);
      // fixed colour once, then silent across the wrap
      run_directed(cfg_type'{mode_select: MODE_FIXED, show_enable: 1'b1, base_red: 8'hFF,
         base_green: 8'h00, base_blue: 8'hFF, step_interval: 16'h0000, brightness: 8'hFF},
         32'hFFFF_FFFF, 32'd1, 2);
      // unused mode acts as fixed, longest interval
      run_directed(cfg_type'{mode_select: MODE_UNUSED, show_enable: 1'b1, base_red: 8'h00,
         base_green: 8'hFF, base_blue: 8'h00, step_interval: 16'hFFFF, brightness: 8'h00},
         32'd100, 32'd65435, 3);
      // disable gives black once
      run_directed(cfg_type'{mode_select: MODE_UNUSED, show_enable: 1'b0, base_red: 8'h00,
         base_green: 8'hFF, base_blue: 8'h00, step_interval: 16'hFFFF, brightness: 8'h00},
         32'd5, 32'd1, 2);
      // breathing from full white, interval across the timestamp wrap
      run_directed(cfg_type'{mode_select: MODE_PULSE, show_enable: 1'b1, base_red: 8'hFF,
         base_green: 8'hFF, base_blue: 8'hFF, step_interval: 16'hFFFF, brightness: 8'h80},
         32'hFFFF_FF00, 32'h0000_8000, 3);
      // breathing from black goes negative and clips
      run_directed(cfg_type'{mode_select: MODE_PULSE, show_enable: 1'b1, base_red: 8'h00,
         base_green: 8'h00, base_blue: 8'h00, step_interval: 16'h0001, brightness: 8'h01},
         32'd5, 32'd1, 3);
      run_directed(cfg_type'{mode_select: MODE_WHEEL, show_enable: 1'b1, base_red: 8'h12,
         base_green: 8'h34, base_blue: 8'h56, step_interval: 16'h0000, brightness: 8'hFF},
         32'd0, 32'd0, 3);

      for (int p = 0; p < PHASES; p++) begin
         s = random_settings(phase_modes[p]);
         if (p == HOLD_PHASE) begin
            s.mode_select = MODE_WHEEL;
            s.show_enable = 1'b1;
         end
         wait_until_drained();
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
            default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
         endcase
         apply_settings(s);
         if (p == HOLD_PHASE) hold_request <= 1'b1;
         if ($urandom_range(3) == 0) stamp_now = 32'hFFFF_FFFF - $urandom_range(200000);
         else stamp_now = $urandom();
         case (mode_type'(s.mode_select))
            MODE_PULSE: n = 150;
            MODE_WHEEL: n = 60;
            default:    n = 40;
         endcase
         repeat (n) send_timestamp(next_stamp());
      end

      wait_until_drained();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("status_led_pattern_generator_tb OK");
      end else begin
         $display("status_led_pattern_generator_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("status_led_pattern_generator_tb NOT OK");
      $finish;
   end

endmodule
